@@ hw/rtl/cfc_pkg.sv @@
// shared types and constants of the cell frequency colorizer
package cfc_pkg;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_RENDER = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_LOAD   = 2'd3
  } op_e;

  localparam logic [2:0] CFG_DECAY      = 3'd0;
  localparam logic [2:0] CFG_RED_ROW    = 3'd1;
  localparam logic [2:0] CFG_GREEN_ROW  = 3'd2;
  localparam logic [2:0] CFG_BLUE_ROW   = 3'd3;
  localparam logic [2:0] CFG_FLUSH_THR  = 3'd4;

  localparam logic [15:0] DECAY_RST     = 16'd62259;
  localparam logic [47:0] RED_ROW_RST   = 48'd4096;
  localparam logic [47:0] GREEN_ROW_RST = 48'd268435456;
  localparam logic [47:0] BLUE_ROW_RST  = 48'd17592186044416;
  localparam logic [30:0] FLUSH_THR_RST = 31'd1;

  localparam int unsigned ST_W   = 32;          // resonator width, Q24.8
  localparam int unsigned MUL_W  = 34;          // shared multiplier operand width
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned RND_W  = 36;          // rounded state product
  localparam int unsigned ACC_W  = 51;          // matrix accumulator
  localparam int unsigned CH_W   = ACC_W - 12;  // channel, Q31.8
  localparam int unsigned DIV_W  = CH_W + 10;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned INTEN_GAIN_MAX = 65280;  // 255.0 in Q31.8

  typedef struct packed {
    op_e         operation;
    logic [11:0] cell_index;
    logic [7:0]  cell_value;
    logic [7:0]  gain_index;
    logic [15:0] gain_value;
  } req_t;

  typedef struct packed {
    logic [11:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } rsp_t;

  typedef struct packed {
    logic             clr_wr;
    logic             item_ld;
    logic             gain_wr;
    logic             mem_rd;
    logic             put_step;
    logic             wb;
    logic             flush_wr;
    logic             sq_step;
    logic             sqrt_step;
    logic             mat_step;
    logic             ch_ld;
    logic             inten_ld;
    logic             gain_rd;
    logic             gmul_step;
    logic             div_step;
    logic             res_clr;
    logic             res_ld;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       sel;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    op_e  in_op;
    logic in_cell_ok;
    logic inten_le0;
    logic inten_small;
    logic out_free;
  } status_t;

  function automatic logic signed [15:0] row_weight(logic [47:0] row, logic [1:0] slot);
    logic signed [15:0] w;
    unique case (slot)
      2'd0:    w = row[15:0];
      2'd1:    w = row[31:16];
      default: w = row[47:32];
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/cfc_ctrl.sv @@
// sequencer of the colorizer: steps the datapath through each request
module cfc_ctrl import cfc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [13:0] {
    S_CLEAR    = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_PUT      = 14'b00000000000100,
    S_WB       = 14'b00000000001000,
    S_FLUSH    = 14'b00000000010000,
    S_SQ       = 14'b00000000100000,
    S_SQRT     = 14'b00000001000000,
    S_MAT      = 14'b00000010000000,
    S_CHLD     = 14'b00000100000000,
    S_DECIDE   = 14'b00001000000000,
    S_GAIN_RD  = 14'b00010000000000,
    S_GAIN_MUL = 14'b00100000000000,
    S_DIV      = 14'b01000000000000,
    S_OUT      = 14'b10000000000000
  } state_e;

  localparam logic [CNT_W-1:0] PUT_LAST  = CNT_W'(4);
  localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(2);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(32);
  localparam logic [CNT_W-1:0] MAT_LAST  = CNT_W'(9);
  localparam logic [CNT_W-1:0] GMUL_LAST = CNT_W'(1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(10);
  localparam logic [1:0]       CH_LAST   = 2'd2;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       sel_q, sel_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    sel_d      = sel_q;
    cmd_o      = '0;
    cmd_o.cnt  = cnt_q;
    cmd_o.sel  = sel_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        cnt_d      = '0;
        sel_d      = '0;
        if (in_valid_i) begin
          cmd_o.item_ld = 1'b1;
          unique case (status_i.in_op)
            OP_LOAD: cmd_o.gain_wr = 1'b1;
            OP_PUT: begin
              if (status_i.in_cell_ok) begin
                cmd_o.mem_rd = 1'b1;
                state_d      = S_PUT;
              end
            end
            OP_FLUSH: begin
              if (status_i.in_cell_ok) begin
                cmd_o.mem_rd = 1'b1;
                state_d      = S_FLUSH;
              end
            end
            OP_RENDER: begin
              cmd_o.res_clr = 1'b1;
              if (status_i.in_cell_ok) begin
                cmd_o.mem_rd = 1'b1;
                state_d      = S_SQ;
              end else begin
                state_d = S_OUT;
              end
            end
          endcase
        end
      end
      S_PUT: begin
        cmd_o.put_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == PUT_LAST) begin
          cnt_d   = '0;
          state_d = S_WB;
        end
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = S_IDLE;
      end
      S_FLUSH: begin
        cmd_o.flush_wr = 1'b1;
        state_d        = S_IDLE;
      end
      S_SQ: begin
        cmd_o.sq_step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == SQ_LAST) begin
          cnt_d   = '0;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == SQRT_LAST) begin
          cnt_d   = '0;
          state_d = S_MAT;
        end
      end
      S_MAT: begin
        cmd_o.mat_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == MAT_LAST) begin
          cnt_d   = '0;
          state_d = S_CHLD;
        end
      end
      S_CHLD: begin
        cmd_o.ch_ld = 1'b1;
        state_d     = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.inten_ld = 1'b1;
        priority if (status_i.inten_le0)   state_d = S_OUT;
        else if (status_i.inten_small)     state_d = S_GAIN_RD;
        else                               state_d = S_DIV;
      end
      S_GAIN_RD: begin
        cmd_o.gain_rd = 1'b1;
        state_d       = S_GAIN_MUL;
      end
      S_GAIN_MUL: begin
        cmd_o.gmul_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == GMUL_LAST) begin
          cnt_d = '0;
          if (sel_q == CH_LAST) state_d = S_OUT;
          else sel_d = sel_q + 1'b1;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          cnt_d = '0;
          if (sel_q == CH_LAST) state_d = S_OUT;
          else sel_d = sel_q + 1'b1;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.res_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
    end
  end

endmodule

@@ hw/rtl/cfc_datapath.sv @@
// datapath of the colorizer: resonator memory, gain table, shared multiplier, root and divider
module cfc_datapath import cfc_pkg::*; #(
  parameter int unsigned NUM_CELLS    = 4096,
  parameter int unsigned GAIN_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  req_t        in_req_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output rsp_t        out_rsp_o
);

  localparam int unsigned AW     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int unsigned GAW    = $clog2(GAIN_ENTRIES);
  localparam int unsigned WORD_W = 4 * ST_W;

  // configuration
  logic [15:0] decay_q;
  logic [47:0] red_row_q, green_row_q, blue_row_q;
  logic [30:0] flush_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q     <= DECAY_RST;
      red_row_q   <= RED_ROW_RST;
      green_row_q <= GREEN_ROW_RST;
      blue_row_q  <= BLUE_ROW_RST;
      flush_thr_q <= FLUSH_THR_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_DECAY)     decay_q     <= cfg_data_i[15:0];
      if (cfg_index_i == CFG_RED_ROW)   red_row_q   <= cfg_data_i;
      if (cfg_index_i == CFG_GREEN_ROW) green_row_q <= cfg_data_i;
      if (cfg_index_i == CFG_BLUE_ROW)  blue_row_q  <= cfg_data_i;
      if (cfg_index_i == CFG_FLUSH_THR) flush_thr_q <= cfg_data_i[30:0];
    end
  end

  function automatic logic signed [RND_W-1:0] round16(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + PROD_W'(32768);
    return t[RND_W+15:16];
  endfunction

  function automatic logic signed [ST_W-1:0] sat_st(logic signed [RND_W-1:0] r);
    logic signed [ST_W-1:0] s;
    if (r[RND_W-1] && !(&r[RND_W-2:ST_W-1]))       s = {1'b1, {(ST_W-1){1'b0}}};
    else if (!r[RND_W-1] && (|r[RND_W-2:ST_W-1]))  s = {1'b0, {(ST_W-1){1'b1}}};
    else                                           s = r[ST_W-1:0];
    return s;
  endfunction

  function automatic logic [ST_W:0] abs_st(logic signed [ST_W-1:0] x);
    logic signed [ST_W:0] e;
    e = (ST_W+1)'(x);
    return x[ST_W-1] ? (ST_W+1)'(-e) : (ST_W+1)'(e);
  endfunction

  // matrix step c covers row c/3, slot c%3
  function automatic logic [1:0] mat_row(logic [3:0] c);
    logic [1:0] r;
    unique case (c)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] mat_slot(logic [3:0] c);
    logic [1:0] s;
    unique case (c)
      4'd0, 4'd3, 4'd6: s = 2'd0;
      4'd1, 4'd4, 4'd7: s = 2'd1;
      default:          s = 2'd2;
    endcase
    return s;
  endfunction

  // request capture
  req_t           item_q;
  logic [31:0]    in_cell_ext, item_cell_ext;
  logic [AW-1:0]  in_addr, item_addr;

  assign in_cell_ext   = 32'(in_req_i.cell_index);
  assign item_cell_ext = 32'(item_q.cell_index);
  assign in_addr       = in_cell_ext[AW-1:0];
  assign item_addr     = item_cell_ext[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_ld) item_q <= in_req_i;
  end

  // resonator memory, one word per cell: {quad_imag, quad_real, alt_sum, dc_sum}
  logic [WORD_W-1:0] st_mem [NUM_CELLS];
  logic [WORD_W-1:0] rdata_q, wdata;
  logic [AW-1:0]     clr_cnt_q, waddr;
  logic              mem_we;

  logic signed [ST_W-1:0] st_dc, st_alt, st_re, st_im;
  assign st_dc  = rdata_q[ST_W-1:0];
  assign st_alt = rdata_q[2*ST_W-1:ST_W];
  assign st_re  = rdata_q[3*ST_W-1:2*ST_W];
  assign st_im  = rdata_q[4*ST_W-1:3*ST_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_cnt_q <= '0;
    else if (cmd_i.clr_wr) clr_cnt_q <= clr_cnt_q + 1'b1;
  end

  logic signed [ST_W-1:0] newst_q [4];
  logic [WORD_W-1:0]      flush_word;
  logic [ST_W:0]          thr_ext;

  assign thr_ext = (ST_W+1)'(flush_thr_q);

  always_comb begin
    flush_word[ST_W-1:0]        = (abs_st(st_dc)  < thr_ext) ? '0 : st_dc;
    flush_word[2*ST_W-1:ST_W]   = (abs_st(st_alt) < thr_ext) ? '0 : st_alt;
    flush_word[3*ST_W-1:2*ST_W] = (abs_st(st_re)  < thr_ext) ? '0 : st_re;
    flush_word[4*ST_W-1:3*ST_W] = (abs_st(st_im)  < thr_ext) ? '0 : st_im;
  end

  always_comb begin
    mem_we = cmd_i.clr_wr | cmd_i.wb | cmd_i.flush_wr;
    waddr  = cmd_i.clr_wr ? clr_cnt_q : item_addr;
    priority if (cmd_i.clr_wr) wdata = '0;
    else if (cmd_i.wb)         wdata = {newst_q[3], newst_q[2], newst_q[1], newst_q[0]};
    else                       wdata = flush_word;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we)       st_mem[waddr] <= wdata;
    if (cmd_i.mem_rd) rdata_q <= st_mem[in_addr];
  end

  // gain table
  logic [15:0]     gain_mem [GAIN_ENTRIES];
  logic [15:0]     gain_q;
  logic [31:0]     gwr_ext, gsat;
  logic [8:0]      gi;
  logic [GAW-1:0]  gidx;
  logic signed [CH_W-1:0] inten_q;

  assign gwr_ext = 32'(in_req_i.gain_index);
  assign gi      = 9'((inten_q[16:0] + 17'd128) >> 8);
  assign gsat    = (32'(gi) > GAIN_ENTRIES - 1) ? 32'(GAIN_ENTRIES - 1) : 32'(gi);
  assign gidx    = gsat[GAW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.gain_wr && (gwr_ext < GAIN_ENTRIES)) gain_mem[gwr_ext[GAW-1:0]] <= in_req_i.gain_value;
    if (cmd_i.gain_rd) gain_q <= gain_mem[gidx];
  end

  // square root of re^2 + im^2, one result bit per step
  logic [63:0] sumsq_q, x_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [35:0] sq_shift, sq_trial;

  assign sq_shift = {rem_q, x_q[63:62]};
  assign sq_trial = {2'b00, root_q, 2'b01};

  // shared multiplier with registered product
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_q;
  logic signed [ACC_W-1:0]   acc_q [3];
  logic signed [CH_W-1:0]    ch_q [3];
  logic signed [CH_W-1:0]    ch_sel;
  logic signed [MUL_W-1:0]   opnd [3];
  logic [3:0]                mat_c, mat_p;
  logic [47:0]               mat_rowv;

  assign opnd[0] = MUL_W'(st_dc);
  assign opnd[1] = MUL_W'(abs_st(st_alt));
  assign opnd[2] = MUL_W'(root_q);
  assign mat_c   = cmd_i.cnt[3:0];
  assign mat_p   = mat_c - 4'd1;
  assign ch_sel  = ch_q[cmd_i.sel];

  always_comb begin
    unique case (mat_row(mat_c))
      2'd0:    mat_rowv = red_row_q;
      2'd1:    mat_rowv = green_row_q;
      default: mat_rowv = blue_row_q;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique if (cmd_i.put_step) begin
      unique case (cmd_i.cnt[1:0])
        2'd0:    mul_a = MUL_W'(st_dc);
        2'd1:    mul_a = MUL_W'(st_alt);
        2'd2:    mul_a = MUL_W'(st_im);
        default: mul_a = MUL_W'(st_re);
      endcase
      mul_b = MUL_W'(decay_q);
    end else if (cmd_i.sq_step) begin
      mul_a = cmd_i.cnt[0] ? MUL_W'(st_im) : MUL_W'(st_re);
      mul_b = mul_a;
    end else if (cmd_i.mat_step) begin
      mul_a = MUL_W'(row_weight(mat_rowv, mat_slot(mat_c)));
      mul_b = opnd[mat_slot(mat_c)];
    end else if (cmd_i.gmul_step) begin
      mul_a = ch_sel[MUL_W-1:0];
      mul_b = MUL_W'(gain_q);
    end else begin
      mul_a = '0;
      mul_b = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // put results
  logic signed [RND_W-1:0] prod_rnd, v_ext;
  logic [1:0]              put_k;

  assign prod_rnd = round16(mul_q);
  assign v_ext    = RND_W'({item_q.cell_value, 8'h00});
  assign put_k    = 2'(cmd_i.cnt - 1'b1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.put_step && (cmd_i.cnt != '0)) begin
      unique case (put_k)
        2'd0:    newst_q[0] <= sat_st(prod_rnd + v_ext);
        2'd1:    newst_q[1] <= sat_st(v_ext - prod_rnd);
        2'd2:    newst_q[2] <= sat_st(v_ext - prod_rnd);
        default: newst_q[3] <= sat_st(prod_rnd);
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_step) begin
      if (cmd_i.cnt == CNT_W'(1)) sumsq_q <= mul_q[63:0];
      else if (cmd_i.cnt == CNT_W'(2)) sumsq_q <= sumsq_q + mul_q[63:0];
    end
    if (cmd_i.sqrt_step) begin
      if (cmd_i.cnt == '0) begin
        x_q    <= sumsq_q;
        rem_q  <= '0;
        root_q <= '0;
      end else begin
        x_q <= {x_q[61:0], 2'b00};
        if (sq_shift >= sq_trial) begin
          rem_q  <= 34'(sq_shift - sq_trial);
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= sq_shift[33:0];
          root_q <= {root_q[30:0], 1'b0};
        end
      end
    end
  end

  // colour matrix accumulate, then round each channel to Q31.8
  logic signed [ACC_W-1:0] acc_in;
  assign acc_in = acc_q[mat_row(mat_p)];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mat_step && (mat_c != 4'd0)) begin
      acc_q[mat_row(mat_p)] <= ((mat_slot(mat_p) == 2'd0) ? ACC_W'(0) : acc_in)
                               + mul_q[ACC_W-1:0];
    end
    if (cmd_i.ch_ld) begin
      for (int j = 0; j < 3; j++) begin
        ch_q[j] <= CH_W'((acc_q[j] + ACC_W'(2048)) >>> 12);
      end
    end
  end

  logic signed [CH_W-1:0] inten;
  always_comb begin
    inten = ch_q[0];
    if (ch_q[1] > inten) inten = ch_q[1];
    if (ch_q[2] > inten) inten = ch_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.inten_ld) inten_q <= inten;
  end

  // channel * 255 / intensity, restoring, one quotient bit per step
  logic [DIV_W-1:0]        drem_q, dvs_q;
  logic [8:0]              quo_q;
  logic signed [DIV_W-1:0] ch_ext, inten_ext, num;

  assign ch_ext    = DIV_W'(ch_sel);
  assign inten_ext = DIV_W'(inten_q);
  assign num       = (ch_ext <<< 8) - ch_ext + (inten_ext >>> 1);

  logic [7:0] chan_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step) begin
      if (cmd_i.cnt == '0) begin
        drem_q <= num;
        dvs_q  <= inten_ext <<< 8;
        quo_q  <= '0;
      end else if (cmd_i.cnt == CNT_W'(10)) begin
        chan_q[cmd_i.sel] <= (ch_sel > 0) ? ((quo_q > 9'd255) ? 8'd255 : quo_q[7:0]) : 8'd0;
      end else begin
        dvs_q <= dvs_q >> 1;
        if (drem_q >= dvs_q) begin
          drem_q <= drem_q - dvs_q;
          quo_q  <= {quo_q[7:0], 1'b1};
        end else begin
          quo_q  <= {quo_q[7:0], 1'b0};
        end
      end
    end
    if (cmd_i.gmul_step && (cmd_i.cnt != '0)) begin
      chan_q[cmd_i.sel] <= (ch_sel > 0) ?
                           ((prod_rnd > RND_W'(255)) ? 8'd255 : prod_rnd[7:0]) : 8'd0;
    end
    if (cmd_i.res_clr) begin
      for (int j = 0; j < 3; j++) chan_q[j] <= '0;
    end
  end

  // output register
  logic out_valid_q;
  rsp_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.res_ld) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      out_q.pixel_index <= item_q.cell_index;
      out_q.red         <= chan_q[0];
      out_q.green       <= chan_q[1];
      out_q.blue        <= chan_q[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign status_o.clr_last    = (clr_cnt_q == AW'(NUM_CELLS - 1));
  assign status_o.in_op       = in_req_i.operation;
  assign status_o.in_cell_ok  = (in_cell_ext < NUM_CELLS);
  assign status_o.inten_le0   = (inten <= 0);
  assign status_o.inten_small = (inten <= CH_W'(INTEN_GAIN_MAX));
  assign status_o.out_free    = !out_valid_q || out_ready_i;

endmodule

@@ hw/rtl/cell_frequency_colorizer_core.sv @@
// Cell frequency colorizer: resonator state per cell, rendered to clamped RGB pixels.
//
// Requests enter on in_valid_i/in_ready_o with an in_req_i payload; pixels leave on
// out_valid_o/out_ready_i with out_rsp_o. Only a render request yields a pixel.
// Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i), used while idle.
// One request is worked on at a time; the request kinds and their steps:
//   load gain entry; flush; put (four passes through the shared multiplier);
//   render: the bit-serial square root, the matrix steps on the one multiplier, then
//   the gain table, or above intensity 255 a restoring divide per channel, or neither
//   when no channel is positive; render of an absent cell goes straight to the output.
// After reset a clearing pass zeroes the resonator memory, one cell a cycle, with
// in_ready_o low; configuration writes are taken during it.
// The gain table is not cleared and must be loaded before renders that use it.
// The pixel waits in an output register; new requests are still taken while it waits,
// and a finished render holds the sequencer until out_ready_i frees the register.
module cell_frequency_colorizer_core import cfc_pkg::*; #(
  parameter int unsigned NUM_CELLS    = 4096,
  parameter int unsigned GAIN_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_rsp_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  cfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cfc_datapath #(
    .NUM_CELLS    (NUM_CELLS),
    .GAIN_ENTRIES (GAIN_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

  // no request is taken while the memory is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.clr_wr |-> !in_ready_o)
    else $error("request accepted during clearing pass");

  // a pixel is only loaded into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.res_ld |-> status.out_free)
    else $error("pixel overwrote a pending one");

  // requests other than render never produce a pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_req_i.operation != OP_RENDER) && !out_valid_o)
    |=> !out_valid_o)
    else $error("pixel produced by a non-render request");

endmodule

@@ sim/tb_top.sv @@
// testbench for the cell frequency colorizer core: random requests checked against a predictor
`timescale 1ns / 1ps

module tb_top;
  import cfc_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  req_t        in_req_i;
  logic        out_valid_o;
  logic        out_ready_i;
  rsp_t        out_rsp_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [47:0] cfg_data_i;

  cell_frequency_colorizer_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i,
    .out_valid_o, .out_ready_i, .out_rsp_o, .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  // predictor state
  longint      dc_q[4096];
  longint      alt_q[4096];
  longint      re_q[4096];
  longint      im_q[4096];
  logic [15:0] gain_q[256];
  logic [15:0] decay_q;
  logic [47:0] rows_q[3];
  logic [30:0] thr_q;

  req_t   req_fifo[$];
  rsp_t   pixel_fifo[$];
  int     errors;
  longint cycles;
  bit     rx_noidle;
  bit     tx_noidle;
  int     hold_cnt;
  bit     hold_req;
  bit     sent;

  localparam longint ST_MAXV = 64'sd2147483647;
  localparam longint ST_MINV = -64'sd2147483648;
  localparam longint CYC_LIMIT = 2000000;

  function automatic longint rnd_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint sat32(longint v);
    return v > ST_MAXV ? ST_MAXV : (v < ST_MINV ? ST_MINV : v);
  endfunction

  function automatic longint iabs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint wgt(logic [47:0] row, int slot);
    logic signed [15:0] w;
    w = row[16*slot +: 16];
    return longint'(w);
  endfunction

  function automatic longint quad_mag(longint re, longint im);
    longint unsigned a, b, m, x, r, bt;
    int s;
    a = iabs(re);
    b = iabs(im);
    m = a > b ? a : b;
    s = 0;
    while ((m >> s) > 64'h80000000) s++;
    a = a >> s;
    b = b >> s;
    x = a * a + b * b;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x = x - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return longint'(r << s);
  endfunction

  function automatic logic [7:0] to_byte(longint v);
    return v < 0 ? 8'd0 : (v > 255 ? 8'd255 : v[7:0]);
  endfunction

  // channels and intensity in Q31.8 of a cell's current state
  function automatic void cell_channels(int c, output longint ch[3], output longint inten);
    longint a, b, m;
    a = dc_q[c];
    b = iabs(alt_q[c]);
    m = quad_mag(re_q[c], im_q[c]);
    for (int i = 0; i < 3; i++)
      ch[i] = rnd_shift(wgt(rows_q[i], 0) * a + wgt(rows_q[i], 1) * b + wgt(rows_q[i], 2) * m, 12);
    inten = ch[0];
    if (ch[1] > inten) inten = ch[1];
    if (ch[2] > inten) inten = ch[2];
  endfunction

  function automatic void colorize(req_t r);
    int c;
    longint d, v, re, ch[3], inten, g;
    rsp_t p;
    c = int'(r.cell_index);
    d = longint'(decay_q);
    v = longint'(r.cell_value) << 8;
    case (r.operation)
      OP_PUT: begin
        re = re_q[c];
        dc_q[c] = sat32(rnd_shift(dc_q[c] * d, 16) + v);
        alt_q[c] = sat32(v - rnd_shift(alt_q[c] * d, 16));
        re_q[c] = sat32(v - rnd_shift(im_q[c] * d, 16));
        im_q[c] = sat32(rnd_shift(re * d, 16));
      end
      OP_FLUSH: begin
        if (iabs(dc_q[c]) < thr_q) dc_q[c] = 0;
        if (iabs(alt_q[c]) < thr_q) alt_q[c] = 0;
        if (iabs(re_q[c]) < thr_q) re_q[c] = 0;
        if (iabs(im_q[c]) < thr_q) im_q[c] = 0;
      end
      OP_LOAD: begin
        gain_q[r.gain_index] = r.gain_value;
      end
      default: begin
        p = '0;
        p.pixel_index = r.cell_index;
        cell_channels(c, ch, inten);
        if (inten > 0 && inten <= 65280) begin
          g = longint'(gain_q[(inten + 128) >>> 8]);
          p.red = ch[0] > 0 ? to_byte(rnd_shift(ch[0] * g, 16)) : 8'd0;
          p.green = ch[1] > 0 ? to_byte(rnd_shift(ch[1] * g, 16)) : 8'd0;
          p.blue = ch[2] > 0 ? to_byte(rnd_shift(ch[2] * g, 16)) : 8'd0;
        end else if (inten > 65280) begin
          p.red = ch[0] > 0 ? to_byte((ch[0] * 255 + inten / 2) / inten) : 8'd0;
          p.green = ch[1] > 0 ? to_byte((ch[1] * 255 + inten / 2) / inten) : 8'd0;
          p.blue = ch[2] > 0 ? to_byte((ch[2] * 255 + inten / 2) / inten) : 8'd0;
        end
        pixel_fifo.push_back(p);
      end
    endcase
  endfunction

  task automatic report(string what, rsp_t got, rsp_t want);
    errors++;
    $display("mismatch %s at %0t: got %h expected %h", what, $time, got, want);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("timeout");
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // driver: next request from the queue, predicted on acceptance
  always @(posedge clk_i) begin
    sent <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      colorize(in_req_i);
      void'(req_fifo.pop_front());
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || sent) begin
      // nothing offered, or the previous request went at the last edge
      if (req_fifo.size() > 0 && (tx_noidle || $urandom_range(99) >= 12)) begin
        in_valid_i <= 1'b1;
        in_req_i <= req_fifo[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixel_fifo.size() == 0) begin
        report("unexpected pixel", out_rsp_o, '0);
      end else begin
        want = pixel_fifo.pop_front();
        if (out_rsp_o.pixel_index !== want.pixel_index) report("pixel_index", out_rsp_o, want);
        if (out_rsp_o.red !== want.red) report("red", out_rsp_o, want);
        if (out_rsp_o.green !== want.green) report("green", out_rsp_o, want);
        if (out_rsp_o.blue !== want.blue) report("blue", out_rsp_o, want);
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req && hold_cnt == 0) hold_cnt <= 3000;
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rx_noidle || $urandom_range(99) >= 12;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [47:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_DECAY:     decay_q = val[15:0];
      CFG_RED_ROW:   rows_q[0] = val;
      CFG_GREEN_ROW: rows_q[1] = val;
      CFG_BLUE_ROW:  rows_q[2] = val;
      CFG_FLUSH_THR: thr_q = val[30:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic req_t make_req(op_e op, int c, int v, int gi, int gv);
    req_t r;
    r.operation = op;
    r.cell_index = 12'(c);
    r.cell_value = 8'(v);
    r.gain_index = 8'(gi);
    r.gain_value = 16'(gv);
    return r;
  endfunction

  // idle wait: queue drained, results in, then a further wait longer than any render
  task automatic drain();
    while (req_fifo.size() > 0 || in_valid_i || pixel_fifo.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic load_all_gains();
    for (int i = 0; i < 256; i++)
      req_fifo.push_back(make_req(OP_LOAD, $urandom_range(4095), $urandom_range(255), i,
                                  $urandom_range(65535)));
  endtask

  // random phase: hot cells get put chains, renders, flushes, loads
  task automatic random_phase(int n);
    int c;
    int r;
    for (int k = 0; k < n; k++) begin
      c = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(7) * 585;
      r = $urandom_range(99);
      if (r < 50)
        req_fifo.push_back(make_req(OP_PUT, c, $urandom_range(255), $urandom_range(255),
                                    $urandom_range(65535)));
      else if (r < 80)
        req_fifo.push_back(make_req(OP_RENDER, c, $urandom_range(255), $urandom_range(255),
                                    $urandom_range(65535)));
      else if (r < 92)
        req_fifo.push_back(make_req(OP_FLUSH, c, $urandom_range(255), $urandom_range(255),
                                    $urandom_range(65535)));
      else
        req_fifo.push_back(make_req(OP_LOAD, c, $urandom_range(255), $urandom_range(255),
                                    $urandom_range(65535)));
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    rx_noidle = 1'b0;
    tx_noidle = 1'b0;
    hold_req = 1'b0;
    hold_cnt = 0;
    sent = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_DECAY;
    cfg_data_i = '0;
    foreach (dc_q[i]) begin
      dc_q[i] = 0; alt_q[i] = 0; re_q[i] = 0; im_q[i] = 0;
    end
    decay_q = DECAY_RST;
    rows_q[0] = RED_ROW_RST;
    rows_q[1] = GREEN_ROW_RST;
    rows_q[2] = BLUE_ROW_RST;
    thr_q = FLUSH_THR_RST;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: whole gain table, extremes of fields, absent-free cells at both ends
    load_all_gains();
    req_fifo.push_back(make_req(OP_RENDER, 0, 0, 0, 0));          // all-zero state
    req_fifo.push_back(make_req(OP_PUT, 0, 255, 255, 65535));
    req_fifo.push_back(make_req(OP_PUT, 0, 255, 0, 0));
    req_fifo.push_back(make_req(OP_RENDER, 0, 0, 0, 0));
    req_fifo.push_back(make_req(OP_PUT, 4095, 1, 0, 0));
    req_fifo.push_back(make_req(OP_RENDER, 4095, 0, 0, 0));
    req_fifo.push_back(make_req(OP_FLUSH, 4095, 0, 0, 0));
    req_fifo.push_back(make_req(OP_RENDER, 4095, 0, 0, 0));
    req_fifo.push_back(make_req(OP_LOAD, 4095, 255, 255, 0));
    req_fifo.push_back(make_req(OP_LOAD, 0, 0, 0, 65535));
    req_fifo.push_back(make_req(OP_RENDER, 0, 0, 0, 0));
    drain();

    // extreme settings: no decay, full decay, saturating weights, big threshold
    cfg_write(CFG_DECAY, 48'hFFFF);
    cfg_write(CFG_RED_ROW, 48'h7FFF_7FFF_7FFF);
    cfg_write(CFG_GREEN_ROW, 48'h8000_8000_8000);
    cfg_write(CFG_BLUE_ROW, 48'h0000_1000_F000);
    cfg_write(CFG_FLUSH_THR, 48'h7FFF_FFFF);
    random_phase(70);
    // receiver holds off while requests keep coming
    hold_req = 1'b1;
    wait (hold_cnt > 0);
    hold_req = 1'b0;
    drain();

    cfg_write(CFG_DECAY, 48'h0);
    cfg_write(CFG_RED_ROW, 48'({$urandom, $urandom} & 48'hFFFF_FFFF_FFFF));
    cfg_write(CFG_GREEN_ROW, 48'h0000_0000_1000);
    cfg_write(CFG_BLUE_ROW, 48'h0);
    cfg_write(CFG_FLUSH_THR, 48'h0);
    random_phase(50);
    drain();

    cfg_write(CFG_DECAY, 48'(DECAY_RST));
    cfg_write(CFG_RED_ROW, 48'h0000_0800_1000);
    cfg_write(CFG_GREEN_ROW, 48'h1000_0000_0400);
    cfg_write(CFG_BLUE_ROW, 48'h0400_1000_0000);
    cfg_write(CFG_FLUSH_THR, 48'd2000);
    tx_noidle = 1'b1;
    rx_noidle = 1'b1;
    random_phase(40);
    drain();
    tx_noidle = 1'b0;
    rx_noidle = 1'b0;

    cfg_write(CFG_DECAY, 48'd60000);
    cfg_write(CFG_RED_ROW, 48'({$urandom, $urandom} & 48'hFFFF_FFFF_FFFF));
    cfg_write(CFG_GREEN_ROW, 48'({$urandom, $urandom} & 48'hFFFF_FFFF_FFFF));
    cfg_write(CFG_BLUE_ROW, 48'({$urandom, $urandom} & 48'hFFFF_FFFF_FFFF));
    cfg_write(CFG_FLUSH_THR, 48'({$urandom, $urandom} & 48'h7FFF_FFFF));
    random_phase(80);
    drain();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
